// ----- hw/rtl/clc_pkg.sv -----
// shared types and constants for the card number luhn classifier
// no dependencies
package clc_pkg;

	localparam int BIN_W      = 63;
	localparam int NUM_DIGITS = 19;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = 6;
	localparam int LEN_W      = 5;

	localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(BIN_W - 1);
	localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_DIGITS - 1);

	localparam logic [1:0] BRAND_INVALID = 2'd0;
	localparam logic [1:0] BRAND_AMEX    = 2'd1;
	localparam logic [1:0] BRAND_MASTER  = 2'd2;
	localparam logic [1:0] BRAND_VISA    = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic scan;
		logic finish;
	} clc_cmd_t;

endpackage

// ----- hw/rtl/card_number_luhn_classifier_core.sv -----
// top level of the card number luhn classifier
// depends on clc_pkg, clc_ctrl and clc_dp

// One card number (63-bit unsigned binary) is taken when start is high and
// busy is low. The number is turned into 19 bcd digits by shift-add-3, one
// input bit per cycle, then the digits are scanned one per cycle from the
// right to form the luhn sum mod ten, the exact digit count and the two
// leading digits. A final cycle decodes the brand. From acceptance, busy
// stays high through conversion, scan and finish, and drops when the result
// appears; the next number can be taken in the cycle the result appears.
// The result (brand, luhn_ok, digit_count) is shown for exactly one
// cycle with done high and cannot be held off; the receiver must take
// it then. Brand is 0 invalid, 1 amex, 2 mastercard, 3 visa, and is
// invalid whenever the luhn check fails. Zero gives a digit count of 0,
// luhn_ok 1 and an invalid brand.
module card_number_luhn_classifier_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [clc_pkg::BIN_W-1:0] acct_num,
	output logic                      done,
	output logic [1:0]                brand,
	output logic                      luhn_ok,
	output logic [clc_pkg::LEN_W-1:0] digit_count
);
	import clc_pkg::*;

	// command bundle from the sequencer into the datapath
	clc_cmd_t cmd;

	// sequencer: counts conversion and scan cycles, raises done
	clc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath: bcd conversion, luhn sum, length and prefix capture
	clc_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.acct_num    (acct_num),
		.brand       (brand),
		.luhn_ok     (luhn_ok),
		.digit_count (digit_count)
	);

endmodule

// ----- hw/rtl/clc_ctrl.sv -----
// controller state machine: load, binary to bcd, digit scan, finish
// depends on clc_pkg
module clc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output clc_pkg::clc_cmd_t cmd
);
	import clc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CONV   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.conv   = (state_q == ST_CONV);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (cnt_q == CONV_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == SCAN_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_CONV && cnt_q == '0))
		else $error("accepted start did not begin conversion");

	a_conv_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && cnt_q == CONV_LAST) |=> (state_q == ST_SCAN))
		else $error("conversion did not hand over to digit scan");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_FINISH && !busy))
		else $error("result strobe without finish step");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.conv, cmd.scan, cmd.finish}))
		else $error("more than one datapath command");

endmodule

// ----- hw/rtl/clc_dp.sv -----
// datapath: shift-add-3 conversion, luhn digit scan, brand decode
// depends on clc_pkg
module clc_dp (
	input  logic                    clk,
	input  clc_pkg::clc_cmd_t       cmd,
	input  logic [clc_pkg::BIN_W-1:0] acct_num,
	output logic [1:0]              brand,
	output logic                    luhn_ok,
	output logic [clc_pkg::LEN_W-1:0] digit_count
);
	import clc_pkg::*;

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;
	logic [3:0]       sum_q;
	logic [3:0]       prev_q;
	logic [3:0]       hi_q;
	logic [3:0]       lo_q;
	logic [3:0]       dig;
	logic [4:0]       dbl;
	logic [3:0]       contrib;
	logic [4:0]       sum5;
	logic [3:0]       sum_next;
	logic [1:0]       brand_d;
	logic [1:0]       brand_q;
	logic             luhn_q;
	logic [LEN_W-1:0] count_q;

	// add 3 to every bcd digit of five or more before the shift
	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
		end
	end

	// luhn contribution of the lowest digit, sum kept mod ten
	always_comb begin
		dig      = bcd_q[3:0];
		dbl      = {dig, 1'b0};
		contrib  = dig;
		if (idx_q[0]) contrib = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
		sum5     = {1'b0, sum_q} + {1'b0, contrib};
		sum_next = (sum5 >= 5'd10) ? 4'(sum5 - 5'd10) : sum5[3:0];
	end

	always_comb begin
		brand_d = BRAND_INVALID;
		if (len_q == LEN_W'(15) && hi_q == 4'd3 && (lo_q == 4'd4 || lo_q == 4'd7))
			brand_d = BRAND_AMEX;
		else if (len_q == LEN_W'(16) && hi_q == 4'd5 && lo_q >= 4'd1 && lo_q <= 4'd5)
			brand_d = BRAND_MASTER;
		else if ((len_q == LEN_W'(13) || len_q == LEN_W'(16)) && hi_q == 4'd4)
			brand_d = BRAND_VISA;
		if (sum_q != 4'd0) brand_d = BRAND_INVALID;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= acct_num;
			bcd_q  <= '0;
			idx_q  <= '0;
			len_q  <= '0;
			sum_q  <= '0;
			prev_q <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else if (cmd.conv) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end else if (cmd.scan) begin
			bcd_q  <= {4'd0, bcd_q[BCD_W-1:4]};
			idx_q  <= idx_q + 1'b1;
			sum_q  <= sum_next;
			prev_q <= dig;
			if (dig != 4'd0) begin
				len_q <= idx_q + 1'b1;
				hi_q  <= dig;
				lo_q  <= prev_q;
			end
		end
		if (cmd.finish) begin
			brand_q <= brand_d;
			luhn_q  <= (sum_q == 4'd0);
			count_q <= len_q;
		end
	end

	assign brand       = brand_q;
	assign luhn_ok     = luhn_q;
	assign digit_count = count_q;

endmodule
